@@ sv/qpc_pkg.sv @@
// Shared types, constants and helpers for the quad plausibility checker.
package qpc_pkg;

	localparam int FRAC_BITS = 4;
	localparam int COORD_W = 18;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0] diff_t;
	typedef logic signed [2*COORD_W-1:0] sprod_t;
	typedef logic signed [2*COORD_W+1:0] cprod_t;
	typedef logic signed [2*COORD_W+2:0] shoe_t;
	typedef logic [2*COORD_W+9:0] area_t;
	typedef logic [2*COORD_W:0] sqp_t;
	typedef logic [2*COORD_W+1:0] sq_t;
	typedef logic [2*COORD_W+5:0] sq9_t;
	typedef logic signed [24:0] pos_t;
	typedef logic [12:0] dim_t;
	typedef logic [25:0] dim2_t;
	typedef logic [2:0] reason_t;
	typedef logic [7:0] reg_idx_t;

	localparam reg_idx_t REG_IMAGE_WIDTH = 8'd0;
	localparam reg_idx_t REG_IMAGE_HEIGHT = 8'd1;

	localparam dim_t WIDTH_RESET = 13'd640;
	localparam dim_t HEIGHT_RESET = 13'd480;

	localparam reason_t REASON_PASS = 3'd0;
	localparam reason_t REASON_AREA_SMALL = 3'd1;
	localparam reason_t REASON_AREA_LARGE = 3'd2;
	localparam reason_t REASON_NOT_CONVEX = 3'd3;
	localparam reason_t REASON_EDGE_SHORT = 3'd4;
	localparam reason_t REASON_RATIO = 3'd5;
	localparam reason_t REASON_OUTSIDE = 3'd6;

	localparam int AREA_LO_SHIFT = 4 + 2 * FRAC_BITS;
	localparam int AREA_HI_SHIFT = 2 * FRAC_BITS;
	localparam sq_t EDGE_MIN_SQ = sq_t'(400 * (1 << (2 * FRAC_BITS)));

	typedef struct packed {
		area_t area_lo;
		area_t area_hi;
		pos_t lo;
		pos_t hix;
		pos_t hiy;
	} cfg_thr_t;

	typedef struct packed {
		coord_t [7:0] pts;
		area_t s100;
		logic convex;
		logic outside;
		sqp_t [3:0] dx2;
		sqp_t [3:0] dy2;
	} geo_t;

	typedef struct packed {
		coord_t [7:0] pts;
		reason_t reason;
		logic plausible;
	} res_t;

	function automatic coord_t sel4(coord_t a, coord_t b, coord_t c, coord_t d,
			logic [1:0] idx);
		coord_t r;
		case (idx)
			2'd0: r = a;
			2'd1: r = b;
			2'd2: r = c;
			default: r = d;
		endcase
		return r;
	endfunction

endpackage

@@ sv/qpc_cfg.sv @@
// Image size registers and derived test thresholds.
module qpc_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input qpc_pkg::reg_idx_t cfg_index,
	input logic [15:0] cfg_data,
	output qpc_pkg::cfg_thr_t thr
);

	qpc_pkg::dim_t width_q, height_q, max_q;
	qpc_pkg::dim2_t wh_q;
	qpc_pkg::cfg_thr_t thr_q;
	qpc_pkg::cfg_thr_t thr_d;
	qpc_pkg::pos_t m7;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= qpc_pkg::WIDTH_RESET;
			height_q <= qpc_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == qpc_pkg::REG_IMAGE_WIDTH)
				width_q <= cfg_data[12:0];
			else if (cfg_index == qpc_pkg::REG_IMAGE_HEIGHT)
				height_q <= cfg_data[12:0];
		end
	end

	always_ff @(posedge clk) begin
		wh_q <= qpc_pkg::dim2_t'(width_q) * qpc_pkg::dim2_t'(height_q);
		max_q <= (width_q > height_q) ? width_q : height_q;
		thr_q <= thr_d;
	end

	always_comb begin
		m7 = qpc_pkg::pos_t'(max_q) * qpc_pkg::pos_t'(7);
		thr_d.area_lo = qpc_pkg::area_t'(wh_q) << qpc_pkg::AREA_LO_SHIFT;
		thr_d.area_hi = (qpc_pkg::area_t'(wh_q) * qpc_pkg::area_t'(190))
			<< qpc_pkg::AREA_HI_SHIFT;
		thr_d.lo = -(m7 <<< qpc_pkg::FRAC_BITS);
		thr_d.hix = (qpc_pkg::pos_t'(width_q) * qpc_pkg::pos_t'(20) + m7)
			<<< qpc_pkg::FRAC_BITS;
		thr_d.hiy = (qpc_pkg::pos_t'(height_q) * qpc_pkg::pos_t'(20) + m7)
			<<< qpc_pkg::FRAC_BITS;
	end

	assign thr = thr_q;

endmodule

@@ sv/qpc_geom.sv @@
// Stages 1-4: corner ordering, shoelace, turn products, edge squares, margin test.
module qpc_geom (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input qpc_pkg::coord_t [7:0] in_pts,
	input qpc_pkg::cfg_thr_t thr,
	output logic out_valid,
	input logic out_ready,
	output qpc_pkg::geo_t out_geo
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: sums, differences, input-order edge vectors
	qpc_pkg::coord_t x_s1 [4], y_s1 [4];
	qpc_pkg::diff_t sum_s1 [4], dif_s1 [4], ex_s1 [4], ey_s1 [4];

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 4; i++) begin
				x_s1[i] <= in_pts[2*i];
				y_s1[i] <= in_pts[2*i+1];
				sum_s1[i] <= qpc_pkg::diff_t'(in_pts[2*i+1]) + qpc_pkg::diff_t'(in_pts[2*i]);
				dif_s1[i] <= qpc_pkg::diff_t'(in_pts[2*i+1]) - qpc_pkg::diff_t'(in_pts[2*i]);
				ex_s1[i] <= qpc_pkg::diff_t'(in_pts[2*((i+1)%4)]) -
					qpc_pkg::diff_t'(in_pts[2*i]);
				ey_s1[i] <= qpc_pkg::diff_t'(in_pts[2*((i+1)%4)+1]) -
					qpc_pkg::diff_t'(in_pts[2*i+1]);
			end
		end
	end

	// stage 2: role selection, products
	logic [1:0] ord_d [4];
	always_comb begin
		qpc_pkg::diff_t bsmin, bsmax, bdmin, bdmax;
		bsmin = sum_s1[0];
		bsmax = sum_s1[0];
		bdmin = dif_s1[0];
		bdmax = dif_s1[0];
		for (int k = 0; k < 4; k++) ord_d[k] = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (sum_s1[i] < bsmin) begin
				bsmin = sum_s1[i];
				ord_d[0] = 2'(i);
			end
			if (dif_s1[i] < bdmin) begin
				bdmin = dif_s1[i];
				ord_d[1] = 2'(i);
			end
			if (sum_s1[i] > bsmax) begin
				bsmax = sum_s1[i];
				ord_d[2] = 2'(i);
			end
			if (dif_s1[i] > bdmax) begin
				bdmax = dif_s1[i];
				ord_d[3] = 2'(i);
			end
		end
	end

	qpc_pkg::coord_t x_s2 [4], y_s2 [4];
	logic [1:0] ord_s2 [4];
	qpc_pkg::sprod_t spa_s2 [4], spb_s2 [4];
	qpc_pkg::cprod_t cpa_s2 [4], cpb_s2 [4];

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 4; i++) begin
				x_s2[i] <= x_s1[i];
				y_s2[i] <= y_s1[i];
				ord_s2[i] <= ord_d[i];
				spa_s2[i] <= qpc_pkg::sprod_t'(x_s1[i]) * qpc_pkg::sprod_t'(y_s1[(i+1)%4]);
				spb_s2[i] <= qpc_pkg::sprod_t'(x_s1[(i+1)%4]) * qpc_pkg::sprod_t'(y_s1[i]);
				cpa_s2[i] <= qpc_pkg::cprod_t'(ex_s1[i]) * qpc_pkg::cprod_t'(ey_s1[(i+1)%4]);
				cpb_s2[i] <= qpc_pkg::cprod_t'(ey_s1[i]) * qpc_pkg::cprod_t'(ex_s1[(i+1)%4]);
			end
		end
	end

	// stage 3: area sum, convexity, ordered corners and edges
	qpc_pkg::coord_t ox_d [4], oy_d [4];
	qpc_pkg::shoe_t s_d;
	logic convex_d;
	always_comb begin
		logic signed [2*qpc_pkg::COORD_W+2:0] c;
		logic allpos, allneg;
		s_d = '0;
		allpos = 1'b1;
		allneg = 1'b1;
		for (int i = 0; i < 4; i++) begin
			s_d = s_d + qpc_pkg::shoe_t'(spa_s2[i]) - qpc_pkg::shoe_t'(spb_s2[i]);
			c = qpc_pkg::shoe_t'(cpa_s2[i]) - qpc_pkg::shoe_t'(cpb_s2[i]);
			if (c <= 0) allpos = 1'b0;
			if (c >= 0) allneg = 1'b0;
		end
		convex_d = allpos || allneg;
		for (int k = 0; k < 4; k++) begin
			ox_d[k] = qpc_pkg::sel4(x_s2[0], x_s2[1], x_s2[2], x_s2[3], ord_s2[k]);
			oy_d[k] = qpc_pkg::sel4(y_s2[0], y_s2[1], y_s2[2], y_s2[3], ord_s2[k]);
		end
	end

	qpc_pkg::coord_t ox_s3 [4], oy_s3 [4];
	qpc_pkg::diff_t edx_s3 [4], edy_s3 [4];
	qpc_pkg::shoe_t s_s3;
	logic convex_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			s_s3 <= s_d;
			convex_s3 <= convex_d;
			for (int k = 0; k < 4; k++) begin
				ox_s3[k] <= ox_d[k];
				oy_s3[k] <= oy_d[k];
				edx_s3[k] <= qpc_pkg::diff_t'(ox_d[k]) - qpc_pkg::diff_t'(ox_d[(k+1)%4]);
				edy_s3[k] <= qpc_pkg::diff_t'(oy_d[k]) - qpc_pkg::diff_t'(oy_d[(k+1)%4]);
			end
		end
	end

	// stage 4: scaled area, squares, margin test
	logic [2*qpc_pkg::COORD_W+1:0] smag;
	logic outside_d;
	always_comb begin
		qpc_pkg::pos_t x20, y20;
		smag = s_s3[2*qpc_pkg::COORD_W+2] ? -s_s3[2*qpc_pkg::COORD_W+1:0]
			: s_s3[2*qpc_pkg::COORD_W+1:0];
		outside_d = 1'b0;
		for (int k = 0; k < 4; k++) begin
			x20 = qpc_pkg::pos_t'(ox_s3[k]) * qpc_pkg::pos_t'(20);
			y20 = qpc_pkg::pos_t'(oy_s3[k]) * qpc_pkg::pos_t'(20);
			if (x20 < thr.lo || x20 > thr.hix || y20 < thr.lo || y20 > thr.hiy)
				outside_d = 1'b1;
		end
	end

	qpc_pkg::geo_t geo_s4;
	always_ff @(posedge clk) begin
		if (en4) begin
			geo_s4.s100 <= qpc_pkg::area_t'(smag) * qpc_pkg::area_t'(100);
			geo_s4.convex <= convex_s3;
			geo_s4.outside <= outside_d;
			for (int k = 0; k < 4; k++) begin
				geo_s4.pts[2*k] <= ox_s3[k];
				geo_s4.pts[2*k+1] <= oy_s3[k];
				geo_s4.dx2[k] <= qpc_pkg::sqp_t'(qpc_pkg::cprod_t'(edx_s3[k]) *
					qpc_pkg::cprod_t'(edx_s3[k]));
				geo_s4.dy2[k] <= qpc_pkg::sqp_t'(qpc_pkg::cprod_t'(edy_s3[k]) *
					qpc_pkg::cprod_t'(edy_s3[k]));
			end
		end
	end

	assign out_geo = geo_s4;

endmodule

@@ sv/qpc_judge.sv @@
// Stages 5-7: edge lengths, area bounds, min/max, verdict.
module qpc_judge (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input qpc_pkg::geo_t in_geo,
	input qpc_pkg::cfg_thr_t thr,
	output logic out_valid,
	input logic out_ready,
	output qpc_pkg::res_t out_res
);

	logic v_s5, v_s6, v_s7;
	logic en5, en6, en7;

	assign en7 = !v_s7 || out_ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign in_ready = en5;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en5) v_s5 <= in_valid;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// stage 5
	qpc_pkg::sq_t sq_s5 [4];
	qpc_pkg::coord_t [7:0] pts_s5;
	logic small_s5, large_s5, convex_s5, outside_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int k = 0; k < 4; k++)
				sq_s5[k] <= qpc_pkg::sq_t'(in_geo.dx2[k]) + qpc_pkg::sq_t'(in_geo.dy2[k]);
			pts_s5 <= in_geo.pts;
			small_s5 <= in_geo.s100 < thr.area_lo;
			large_s5 <= in_geo.s100 > thr.area_hi;
			convex_s5 <= in_geo.convex;
			outside_s5 <= in_geo.outside;
		end
	end

	// stage 6
	qpc_pkg::sq_t mn_d, mx_d;
	always_comb begin
		qpc_pkg::sq_t mna, mnb, mxa, mxb;
		mna = (sq_s5[1] < sq_s5[0]) ? sq_s5[1] : sq_s5[0];
		mnb = (sq_s5[3] < sq_s5[2]) ? sq_s5[3] : sq_s5[2];
		mxa = (sq_s5[1] > sq_s5[0]) ? sq_s5[1] : sq_s5[0];
		mxb = (sq_s5[3] > sq_s5[2]) ? sq_s5[3] : sq_s5[2];
		mn_d = (mnb < mna) ? mnb : mna;
		mx_d = (mxb > mxa) ? mxb : mxa;
	end

	qpc_pkg::sq_t mn_s6, mx_s6;
	qpc_pkg::coord_t [7:0] pts_s6;
	logic small_s6, large_s6, convex_s6, outside_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			mn_s6 <= mn_d;
			mx_s6 <= mx_d;
			pts_s6 <= pts_s5;
			small_s6 <= small_s5;
			large_s6 <= large_s5;
			convex_s6 <= convex_s5;
			outside_s6 <= outside_s5;
		end
	end

	// stage 7
	qpc_pkg::reason_t reason_d;
	always_comb begin
		qpc_pkg::sq9_t mn9;
		mn9 = qpc_pkg::sq9_t'(mn_s6) * qpc_pkg::sq9_t'(9);
		if (small_s6) reason_d = qpc_pkg::REASON_AREA_SMALL;
		else if (large_s6) reason_d = qpc_pkg::REASON_AREA_LARGE;
		else if (!convex_s6) reason_d = qpc_pkg::REASON_NOT_CONVEX;
		else if (mn_s6 < qpc_pkg::EDGE_MIN_SQ) reason_d = qpc_pkg::REASON_EDGE_SHORT;
		else if (qpc_pkg::sq9_t'(mx_s6) > mn9) reason_d = qpc_pkg::REASON_RATIO;
		else if (outside_s6) reason_d = qpc_pkg::REASON_OUTSIDE;
		else reason_d = qpc_pkg::REASON_PASS;
	end

	qpc_pkg::res_t res_s7;
	always_ff @(posedge clk) begin
		if (en7) begin
			res_s7.pts <= pts_s6;
			res_s7.reason <= reason_d;
			res_s7.plausible <= (reason_d == qpc_pkg::REASON_PASS);
		end
	end

	assign out_res = res_s7;

endmodule

@@ sv/quad_plausibility_check.sv @@
// Top level of the quad plausibility checker.
//   channel   dir  handshake                      word
//   s_axis    in   s_axis_tvalid/s_axis_tready    8 corner coordinates
//   m_axis    out  m_axis_tvalid/m_axis_tready    verdict and ordered corners
//   cfg       in   cfg_valid/cfg_ready            register index and data
// Seven register stages from input to output; one word per cycle when not stalled.
// Each stage holds its word while the next is full; bubbles collapse.
// arst_n clears the valid bits and loads the 640 x 480 image size.
module quad_plausibility_check (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
	input logic [143:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// plausible, fail_reason, top_left_x, top_left_y, top_right_x, top_right_y,
	// bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y, 4 zero bits
	output logic [151:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [15:0] cfg_data
);

	qpc_pkg::cfg_thr_t thr;
	qpc_pkg::geo_t geo;
	qpc_pkg::res_t res;
	logic geo_valid, geo_ready;

	qpc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.thr(thr)
	);

	qpc_geom u_geom (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_pts(s_axis_tdata),
		.thr(thr),
		.out_valid(geo_valid),
		.out_ready(geo_ready),
		.out_geo(geo)
	);

	qpc_judge u_judge (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(geo_valid),
		.in_ready(geo_ready),
		.in_geo(geo),
		.thr(thr),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(res)
	);

	assign m_axis_tdata = {4'b0000, res.pts, res.reason, res.plausible};

	a_pass_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == qpc_pkg::REASON_PASS)))
		else $error("plausible flag disagrees with fail reason");

	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3:1] != 3'd7))
		else $error("fail reason out of range");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

endmodule
